[rtl/collision_shade_corner_overlay_unit_defines.svh]
// Assertion macros shared by the overlay unit RTL.
// Depends on nothing; sites that use the macros must have clk and rst_n in scope.
`ifndef COLLISION_SHADE_CORNER_OVERLAY_UNIT_DEFINES_SVH
`define COLLISION_SHADE_CORNER_OVERLAY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CSCO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csco assertion failed");
// Next-cycle implication, checked outside reset.
`define CSCO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csco assertion failed");
`else
`define CSCO_ASSERT_IMP(lbl, ante, cons)
`define CSCO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/csco_pkg.sv]
// Shared types and constants for the collision shade / corner overlay unit.
// No dependencies.
package csco_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 8;
  localparam int PROB_W    = 17;
  localparam int MARKER_W  = 19;
  localparam int CENTER_W  = 9;
  localparam int DIFF_W    = 11;
  localparam int SCALE_W   = 17;
  localparam int PROD_W    = 25;
  localparam int N_SECT    = 3;
  localparam int N_MARK    = 4;
  localparam int ARM_REACH = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 5;
  localparam int IDX_W     = 3;

  localparam int MK_COL_LSB = 0;
  localparam int MK_ROW_LSB = 9;
  localparam int MK_VIS_BIT = 18;

  localparam logic [SCALE_W-1:0] ONE_FIX    = 17'h10000;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 25'h0008000;
  localparam logic [PIX_W-1:0]   PIX_MAX    = 8'hFF;

  localparam int FRAME_WIDTH_DEF  = 160;
  localparam int FRAME_HEIGHT_DEF = 160;

  typedef enum logic [IDX_W-1:0] {
    REG_PROB_LEFT    = 3'd0,
    REG_PROB_CENTER  = 3'd1,
    REG_PROB_RIGHT   = 3'd2,
    REG_MARKER_ZERO  = 3'd3,
    REG_MARKER_ONE   = 3'd4,
    REG_MARKER_TWO   = 3'd5,
    REG_MARKER_THREE = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    SECT_LEFT   = 2'd0,
    SECT_CENTER = 2'd1,
    SECT_RIGHT  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [N_SECT-1:0][PROB_W-1:0]   prob;
    logic [N_MARK-1:0][MARKER_W-1:0] marker;
  } cfg_t;

endpackage

[rtl/csco_regs.sv]
// APB register file: three sector probabilities and four crosshair markers.
// Depends on csco_pkg.
module csco_regs
  import csco_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [N_SECT-1:0][PROB_W-1:0]   prob_r, prob_nxt;
  logic [N_MARK-1:0][MARKER_W-1:0] marker_r, marker_nxt;
  logic [IDX_W-1:0]                idx;
  logic                            wr_en;

  assign idx    = paddr[APB_AW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    prob_nxt   = prob_r;
    marker_nxt = marker_r;
    if (wr_en) begin
      case (reg_idx_t'(idx))
        REG_PROB_LEFT:    prob_nxt[0]   = pwdata[PROB_W-1:0];
        REG_PROB_CENTER:  prob_nxt[1]   = pwdata[PROB_W-1:0];
        REG_PROB_RIGHT:   prob_nxt[2]   = pwdata[PROB_W-1:0];
        REG_MARKER_ZERO:  marker_nxt[0] = pwdata[MARKER_W-1:0];
        REG_MARKER_ONE:   marker_nxt[1] = pwdata[MARKER_W-1:0];
        REG_MARKER_TWO:   marker_nxt[2] = pwdata[MARKER_W-1:0];
        REG_MARKER_THREE: marker_nxt[3] = pwdata[MARKER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_r   <= '0;
      marker_r <= '0;
    end else begin
      prob_r   <= prob_nxt;
      marker_r <= marker_nxt;
    end
  end

  always_comb begin
    case (reg_idx_t'(idx))
      REG_PROB_LEFT:    prdata = APB_DW'(prob_r[0]);
      REG_PROB_CENTER:  prdata = APB_DW'(prob_r[1]);
      REG_PROB_RIGHT:   prdata = APB_DW'(prob_r[2]);
      REG_MARKER_ZERO:  prdata = APB_DW'(marker_r[0]);
      REG_MARKER_ONE:   prdata = APB_DW'(marker_r[1]);
      REG_MARKER_TWO:   prdata = APB_DW'(marker_r[2]);
      REG_MARKER_THREE: prdata = APB_DW'(marker_r[3]);
      default:          prdata = '0;
    endcase
  end

  assign cfg.prob   = prob_r;
  assign cfg.marker = marker_r;

endmodule

[rtl/csco_marker.sv]
// Crosshair hit test for one corner marker against one pixel position.
// Depends on csco_pkg.
module csco_marker
  import csco_pkg::*;
(
  input  logic [MARKER_W-1:0] marker,
  input  logic [COORD_W-1:0]  col,
  input  logic [COORD_W-1:0]  row,
  output logic                hit
);

  localparam logic signed [DIFF_W-1:0] REACH_POS = DIFF_W'(ARM_REACH);
  localparam logic signed [DIFF_W-1:0] REACH_NEG = -REACH_POS;

  logic signed [DIFF_W-1:0] cx, cy, px, py, dx, dy;
  logic                     on_row, on_col, near_x, near_y;

  assign cx = DIFF_W'($signed(marker[MK_COL_LSB +: CENTER_W]));
  assign cy = DIFF_W'($signed(marker[MK_ROW_LSB +: CENTER_W]));
  assign px = $signed({{(DIFF_W-COORD_W){1'b0}}, col});
  assign py = $signed({{(DIFF_W-COORD_W){1'b0}}, row});
  assign dx = px - cx;
  assign dy = py - cy;

  assign on_row = (py == cy);
  assign on_col = (px == cx);
  assign near_x = (dx >= REACH_NEG) && (dx <= REACH_POS);
  assign near_y = (dy >= REACH_NEG) && (dy <= REACH_POS);

  assign hit = marker[MK_VIS_BIT] && ((on_row && near_x) || (on_col && near_y));

endmodule

[rtl/csco_pipe.sv]
// Four-stage datapath: sector/hit decode, scale, multiply-round, clamp/overlay.
// Depends on csco_pkg, csco_marker and the assertion macro header.
`include "collision_shade_corner_overlay_unit_defines.svh"
module csco_pipe
  import csco_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [PIX_W-1:0]   pix,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  cfg_t               cfg,
  output logic               out_valid,
  output logic [PIX_W-1:0]   pix_out
);

  localparam int LIM_W = 12;
  localparam logic [LIM_W-1:0] SECT1_LIM = LIM_W'(FRAME_WIDTH);
  localparam logic [LIM_W-1:0] SECT2_LIM = LIM_W'(2 * FRAME_WIDTH);
  localparam logic [LIM_W-1:0] WIDTH_LIM = LIM_W'(FRAME_WIDTH);
  localparam logic [LIM_W-1:0] HEIGHT_LIM = LIM_W'(FRAME_HEIGHT);

  // stage 1 decode
  logic [LIM_W-1:0]  col3;
  sector_t           sector;
  logic [PROB_W-1:0] p_sel, p_nxt;
  logic              in_frame;
  logic [N_MARK-1:0] mk_hit, hit1_nxt;

  logic              v1_r, v2_r, v3_r, vout_r;
  logic [PIX_W-1:0]  pix1_r, pix2_r, pix_out_r, pix_out_nxt;
  logic [PROB_W-1:0] p1_r;
  logic [N_MARK-1:0] hit1_r;
  logic              hit2_r, hit3_r;
  logic [SCALE_W-1:0] scale2_r, scale2_nxt;
  logic [PROB_W:0]    three_p;
  logic [PROD_W-1:0]  prod3_r, prod3_nxt;
  logic [PIX_W:0]     res9;

  // sector = floor(3*col/W), capped at the right sector
  assign col3 = LIM_W'(col) + LIM_W'({col, 1'b0});

  always_comb begin
    if (col3 >= SECT2_LIM)      sector = SECT_RIGHT;
    else if (col3 >= SECT1_LIM) sector = SECT_CENTER;
    else                        sector = SECT_LEFT;
  end

  always_comb begin
    case (sector)
      SECT_LEFT:   p_sel = cfg.prob[0];
      SECT_CENTER: p_sel = cfg.prob[1];
      default:     p_sel = cfg.prob[2];
    endcase
  end

  // saturate at 1.0
  assign p_nxt = (p_sel > PROB_W'(ONE_FIX)) ? PROB_W'(ONE_FIX) : p_sel;

  assign in_frame = (LIM_W'(col) < WIDTH_LIM) && (LIM_W'(row) < HEIGHT_LIM);

  for (genvar g = 0; g < N_MARK; g++) begin : g_mark
    csco_marker u_marker (
      .marker (cfg.marker[g]),
      .col    (col),
      .row    (row),
      .hit    (mk_hit[g])
    );
  end

  assign hit1_nxt = in_frame ? mk_hit : '0;

  // stage 2: scale = 1 - 0.75p
  assign three_p    = {p1_r, 1'b0} + {1'b0, p1_r};
  assign scale2_nxt = ONE_FIX - SCALE_W'(three_p[PROB_W:2]);

  // stage 3: multiply and add half for round to nearest
  assign prod3_nxt = (PROD_W'(pix2_r) * PROD_W'(scale2_r)) + ROUND_HALF;

  // stage 4: drop fraction, clamp, force crosshair pixels
  assign res9        = prod3_r[PROD_W-1:16];
  assign pix_out_nxt = (hit3_r || res9[PIX_W]) ? PIX_MAX : res9[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      vout_r <= 1'b0;
    end else begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      vout_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    pix1_r    <= pix;
    p1_r      <= p_nxt;
    hit1_r    <= hit1_nxt;
    pix2_r    <= pix1_r;
    scale2_r  <= scale2_nxt;
    hit2_r    <= |hit1_r;
    prod3_r   <= prod3_nxt;
    hit3_r    <= hit2_r;
    pix_out_r <= pix_out_nxt;
  end

  assign out_valid = vout_r;
  assign pix_out   = pix_out_r;

  `CSCO_ASSERT_IMP(a_scale_range, v2_r, (scale2_r >= 17'h04000) && (scale2_r <= ONE_FIX))
  `CSCO_ASSERT_NXT(a_hit_forces_max, v3_r && hit3_r, pix_out_r == PIX_MAX)
  `CSCO_ASSERT_NXT(a_valid_advance, v3_r, vout_r)

endmodule

[rtl/collision_shade_corner_overlay_unit.sv]
// Top level of the collision shade / corner crosshair overlay unit.
// Depends on csco_pkg, csco_regs, csco_pipe and the assertion macro header.
//
// Usage:
//   Pixel channel: drive in_pixel_in, in_column and in_row with start high; the
//   request is taken at any rising edge where start is high and busy is low.
//   busy is low whenever reset is released, so one pixel is taken every clock.
//   Result channel: out_pixel_out is shown for one cycle with out_valid high,
//   once the request has passed the decode, scale, multiply and clamp/overlay
//   stage registers. Results leave in request order.
//   Throughput is one pixel per clock, set by the four-stage datapath
//   (sector/crosshair decode, scale, 8x17 multiply with rounding, clamp and
//   overlay) that holds one pixel per stage.
//   The receiver cannot stall; the pipeline never holds, so nothing backs up.
//   Configuration: APB, register i at byte address 4*i (probabilities left,
//   center, right, then four crosshair markers). Write only while no pixel
//   is in flight. pready is always high; reads return the register value.
//   Reset (rst_n low, synchronous): clear the config registers and valid bits;
//   busy stays high while reset is held so no request is dropped.
`include "collision_shade_corner_overlay_unit_defines.svh"
module collision_shade_corner_overlay_unit
  import csco_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // pixel request channel
  input  logic               start,
  output logic               busy,
  input  logic [PIX_W-1:0]   in_pixel_in,
  input  logic [COORD_W-1:0] in_column,
  input  logic [COORD_W-1:0] in_row,
  // result channel
  output logic               out_valid,
  output logic [PIX_W-1:0]   out_pixel_out,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  logic accept;

  // hold off requests only while reset is asserted
  assign busy   = ~rst_n;
  assign accept = start && !busy;

  csco_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // advance one pixel per stage each clock
  csco_pipe #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .pix       (in_pixel_in),
    .col       (in_column),
    .row       (in_row),
    .cfg       (cfg),
    .out_valid (out_valid),
    .pix_out   (out_pixel_out)
  );

  // every accepted request leaves as a result unless reset intervened
  `CSCO_ASSERT_IMP(a_req_to_result, $past(accept, 4) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3), out_valid)
  `CSCO_ASSERT_IMP(a_no_phantom_result, !$past(accept, 4), !out_valid)

endmodule
